### rtl/legendre_2d_poly_eval_defines.svh
// Assertion helpers shared by the RTL.
`ifndef LEGENDRE_2D_POLY_EVAL_DEFINES_SVH
`define LEGENDRE_2D_POLY_EVAL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define LPE_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpe check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define LPE_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpe check failed");

`endif

### rtl/lpe_pkg.sv
package lpe_pkg;

	localparam int MAX_ORDER   = 7;
	localparam int STORE_DEPTH = 64;

	localparam int WORD_W    = 32;
	localparam int ORD_W     = 3;
	localparam int SLOT_W    = 6;
	localparam int CFG_IDX_W = 3;
	localparam int ACC_W     = 64;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_X_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_X_ORDER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_ORDER = 3'd5;

	localparam logic signed [WORD_W-1:0] ONE_Q30 = 32'sh4000_0000;
	localparam logic signed [WORD_W-1:0] Q30_MAX = 32'sh7fff_ffff;
	localparam logic signed [WORD_W-1:0] Q30_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic clear;
		logic issue;
		logic rd_ok;
	} mac_ctl_t;

	typedef struct packed {
		logic active;
		logic sat;
	} mac_sts_t;

	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [47:0] v);
		logic signed [WORD_W-1:0] r;
		if (v > 48'sh0000_7fff_ffff) begin
			r = Q30_MAX;
		end else if (v < -48'sh0000_8000_0000) begin
			r = Q30_MIN;
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/lpe_axis.sv
module lpe_axis #(
	parameter int MAX_ORDER = lpe_pkg::MAX_ORDER,
	localparam int PW = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [31:0]        coord,
	input  logic signed [31:0]        lo,
	input  logic signed [31:0]        hi,
	input  logic [lpe_pkg::ORD_W-1:0] order,
	input  logic [PW-1:0]             rd_idx,
	output logic                      done,
	output logic signed [31:0]        rd_val
);

	typedef enum logic [8:0] {
		AX_IDLE = 9'b000000001,
		AX_DIV  = 9'b000000010,
		AX_MAP  = 9'b000000100,
		AX_MUL  = 9'b000001000,
		AX_RND  = 9'b000010000,
		AX_TERM = 9'b000100000,
		AX_ABS  = 9'b001000000,
		AX_QDIV = 9'b010000000,
		AX_FIN  = 9'b100000000
	} ax_state_t;

	ax_state_t state_q;
	logic      done_q;
	logic [5:0] cnt_q;
	logic [2:0] n_q;

	logic signed [31:0] pv_q [0:MAX_ORDER];
	logic [63:0]        num_q;
	logic [31:0]        rem_q;
	logic [31:0]        w_q;
	logic               neg_q;
	logic               spec_q;
	logic signed [31:0] r_q;
	logic signed [31:0] p1_q;
	logic signed [31:0] p2_q;
	logic signed [63:0] prod_q;
	logic signed [33:0] m_q;
	logic signed [39:0] t_q;
	logic [39:0]        a_q;
	logic [2:0]         rem3_q;
	logic               tneg_q;

	// range mapping
	logic signed [33:0] d0, w0, dn, wa;
	logic signed [35:0] d2, wa36;
	logic               cut_lo, cut_hi;
	logic [31:0]        mag;
	logic [63:0]        numer;
	logic [32:0]        rem2;
	logic               ge;
	logic signed [35:0] rs;
	logic signed [31:0] r_map;
	// recurrence
	logic [4:0]         k1, k2;
	logic signed [39:0] t_next;
	logic [7:0]         qbyte;
	logic [2:0]         rem3;
	logic [3:0]         rem4;
	logic signed [40:0] qs;
	logic signed [31:0] pn;
	logic signed [63:0] rnd;

	always_comb begin
		d0     = 34'(coord) - 34'(lo);
		w0     = 34'(hi) - 34'(lo);
		dn     = w0[33] ? -d0 : d0;
		wa     = w0[33] ? -w0 : w0;
		d2     = 36'(dn) <<< 1;
		wa36   = 36'(wa);
		cut_lo = d2 < -wa36;
		cut_hi = d2 >= 3 * wa36;
		mag    = dn[33] ? 32'(-dn) : 32'(dn);
		numer  = {1'b0, mag, 31'b0} + {33'b0, wa[31:1]};
		rem2   = {rem_q, num_q[63]};
		ge     = rem2 >= {1'b0, w_q};
		rs     = neg_q ? -$signed({3'b0, num_q[32:0]}) : $signed({3'b0, num_q[32:0]});
		r_map  = spec_q ? r_q : lpe_pkg::sat32(48'(rs - 36'sd1073741824));
		rnd    = (prod_q + 64'sd536870912) >>> 30;
		k1     = {1'b0, n_q, 1'b0} - 5'd1;
		k2     = {2'b0, n_q} - 5'd1;
		t_next = 40'(m_q) * $signed({35'b0, k1}) - 40'(p2_q) * $signed({35'b0, k2});
		qs     = tneg_q ? -$signed({1'b0, a_q}) : $signed({1'b0, a_q});
		pn     = lpe_pkg::sat32(48'(qs));
	end

	// eight quotient bits per cycle; the divisor is the degree, 2..7
	always_comb begin
		rem3  = rem3_q;
		qbyte = '0;
		rem4  = '0;
		for (int k = 0; k < 8; k++) begin
			rem4 = {rem3, a_q[39 - k]};
			if (rem4 >= {1'b0, n_q}) begin
				rem4         = rem4 - {1'b0, n_q};
				qbyte[7 - k] = 1'b1;
			end
			rem3 = rem4[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AX_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			n_q     <= '0;
		end else begin
			case (state_q)
				AX_IDLE: begin
					if (start) begin
						done_q  <= 1'b0;
						cnt_q   <= 6'd63;
						state_q <= (cut_lo || cut_hi) ? AX_MAP : AX_DIV;
					end
				end
				AX_DIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						state_q <= AX_MAP;
					end
				end
				AX_MAP: begin
					n_q <= 3'd2;
					if (order < 3'd2) begin
						done_q  <= 1'b1;
						state_q <= AX_IDLE;
					end else begin
						state_q <= AX_MUL;
					end
				end
				AX_MUL:  state_q <= AX_RND;
				AX_RND:  state_q <= AX_TERM;
				AX_TERM: state_q <= AX_ABS;
				AX_ABS: begin
					cnt_q   <= 6'd4;
					state_q <= AX_QDIV;
				end
				AX_QDIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						state_q <= AX_FIN;
					end
				end
				AX_FIN: begin
					if (n_q == order) begin
						done_q  <= 1'b1;
						state_q <= AX_IDLE;
					end else begin
						n_q     <= n_q + 3'd1;
						state_q <= AX_MUL;
					end
				end
				default: state_q <= AX_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			AX_IDLE: begin
				num_q  <= numer;
				rem_q  <= '0;
				w_q    <= wa[31:0];
				neg_q  <= dn[33];
				spec_q <= cut_lo || cut_hi;
				r_q    <= cut_lo ? lpe_pkg::Q30_MIN : lpe_pkg::Q30_MAX;
			end
			AX_DIV: begin
				rem_q <= ge ? 32'(rem2 - {1'b0, w_q}) : rem2[31:0];
				num_q <= {num_q[62:0], ge};
			end
			AX_MAP: begin
				pv_q[0] <= lpe_pkg::ONE_Q30;
				if (order >= 3'd1) begin
					pv_q[PW'(1)] <= r_map;
				end
				r_q  <= r_map;
				p1_q <= r_map;
				p2_q <= lpe_pkg::ONE_Q30;
			end
			AX_MUL:  prod_q <= 64'(r_q) * 64'(p1_q);
			AX_RND:  m_q <= rnd[33:0];
			AX_TERM: t_q <= t_next;
			AX_ABS: begin
				a_q    <= 40'(t_q[39] ? -t_q : t_q) + {38'b0, n_q[2:1]};
				tneg_q <= t_q[39];
				rem3_q <= '0;
			end
			AX_QDIV: begin
				a_q    <= {a_q[31:0], qbyte};
				rem3_q <= rem3;
			end
			AX_FIN: begin
				pv_q[PW'(n_q)] <= pn;
				p2_q <= p1_q;
				p1_q <= pn;
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign rd_val = pv_q[rd_idx];

endmodule

### rtl/lpe_mac.sv
module lpe_mac #(
	parameter int STORE_DEPTH = lpe_pkg::STORE_DEPTH,
	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lpe_pkg::mac_ctl_t        ctl,
	input  logic [AW-1:0]            rd_addr,
	input  logic signed [31:0]       px,
	input  logic signed [31:0]       py,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic signed [31:0]       wr_data,
	output lpe_pkg::mac_sts_t        sts,
	output logic signed [63:0]       acc
);

	logic signed [31:0] mem [0:STORE_DEPTH-1];

	logic               v_s1, v_s2, v_s3;
	logic               ok_s1;
	logic signed [31:0] coef_s1;
	logic signed [63:0] prod_s1;
	logic signed [63:0] raw_s2;
	logic signed [63:0] term_s3;
	logic signed [63:0] acc_q;
	logic               sat_q;

	logic signed [63:0] rnd_pr;
	logic signed [31:0] pr;
	logic signed [31:0] coefm;
	logic signed [63:0] rnd_term;
	logic signed [64:0] sum;

	always_comb begin
		rnd_pr   = (prod_s1 + 64'sd536870912) >>> 30;
		pr       = lpe_pkg::sat32(rnd_pr[47:0]);
		coefm    = ok_s1 ? coef_s1 : '0;
		rnd_term = (raw_s2 + 64'sd8192) >>> 14;
		sum      = 65'(acc_q) + 65'(term_s3);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		coef_s1 <= mem[rd_addr];
		ok_s1   <= ctl.rd_ok;
		prod_s1 <= 64'(px) * 64'(py);
		raw_s2  <= 64'(coefm) * 64'(pr);
		term_s3 <= rnd_term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			acc_q <= '0;
			sat_q <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (ctl.clear) begin
				acc_q <= '0;
				sat_q <= 1'b0;
			end else if (v_s3) begin
				// clip to the 64-bit range and keep going from the clipped value
				if (sum[64] != sum[63]) begin
					acc_q <= sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
					sat_q <= 1'b1;
				end else begin
					acc_q <= sum[63:0];
				end
			end
		end
	end

	assign sts.active = v_s1 | v_s2 | v_s3;
	assign sts.sat    = sat_q;
	assign acc        = acc_q;

endmodule

### rtl/legendre_2d_poly_eval.sv
// 2D tensor-product Legendre series evaluator.
// Input: start with operation, coef_slot, coef_word, x_coord, y_coord; an item
// transfers on a clock edge with start high and busy low.
// A load writes coef_word (Q16.16) into coefficient slot coef_slot in that
// cycle, gives no result and never raises busy.
// An evaluate maps x and y onto [-1,1] (a restoring divider per axis,
// both axes in parallel), runs the Legendre recurrence for each degree
// above one (one shared multiplier per axis), then walks the
// coefficient memory at one multiply-accumulate per cycle.
// An axis whose point maps beyond the Q2.30 span skips its divide.
// One item at a time; a zero-width range returns its result the cycle after.
// Each result shows on series_value, range_error and saturated for one cycle
// with done high; the receiver cannot stall, so it must take it then.
// Configuration: cfg_we, cfg_index, cfg_data, one register per edge, to be
// written while busy is low. Reset restores the default ranges and orders;
// coefficient memory content is undefined until loaded.
`include "legendre_2d_poly_eval_defines.svh"
module legendre_2d_poly_eval #(
	parameter int MAX_ORDER   = lpe_pkg::MAX_ORDER,
	parameter int STORE_DEPTH = lpe_pkg::STORE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [lpe_pkg::SLOT_W-1:0]    coef_slot,
	input  logic signed [31:0]            coef_word,
	input  logic signed [31:0]            x_coord,
	input  logic signed [31:0]            y_coord,
	input  logic                          cfg_we,
	input  logic [lpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output logic                          done,
	output logic signed [63:0]            series_value,
	output logic                          range_error,
	output logic                          saturated
);

	localparam int PW = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_AXES  = 4'b0010,
		ST_MAC   = 4'b0100,
		ST_DRAIN = 4'b1000
	} st_t;

	st_t state_q;

	logic signed [31:0] x_low_q, x_high_q, y_low_q, y_high_q;
	logic [2:0]         x_order_q, y_order_q;
	logic [2:0]         xo, yo;
	logic [2:0]         i_q, j_q;
	logic [5:0]         idx_q;

	logic               done_q, rerr_q, sat_out_q;
	logic signed [63:0] value_q;

	logic               accept, rng_bad, ax_start;
	logic               x_done, y_done;
	logic signed [31:0] px, py;
	logic [8:0]         slot_ext, idx_ext;
	logic               wr_en;
	lpe_pkg::mac_ctl_t  mac_ctl;
	lpe_pkg::mac_sts_t  mac_sts;
	logic signed [63:0] acc;

	always_comb begin
		xo = ({29'b0, x_order_q} > 32'(MAX_ORDER)) ? 3'(MAX_ORDER) : x_order_q;
		yo = ({29'b0, y_order_q} > 32'(MAX_ORDER)) ? 3'(MAX_ORDER) : y_order_q;
		busy          = state_q != ST_IDLE;
		accept        = start && !busy;
		rng_bad       = (x_high_q == x_low_q) || (y_high_q == y_low_q);
		ax_start      = accept && operation == lpe_pkg::OP_EVAL && !rng_bad;
		slot_ext      = {3'b0, coef_slot};
		idx_ext       = {3'b0, idx_q};
		wr_en         = accept && operation == lpe_pkg::OP_LOAD
		                && slot_ext < 9'(STORE_DEPTH);
		mac_ctl.clear = ax_start;
		mac_ctl.issue = state_q == ST_MAC;
		mac_ctl.rd_ok = idx_ext < 9'(STORE_DEPTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q   <= '0;
			x_high_q  <= 32'sd65536;
			y_low_q   <= '0;
			y_high_q  <= 32'sd65536;
			x_order_q <= '0;
			y_order_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lpe_pkg::CFG_X_LOW:   x_low_q   <= cfg_data;
				lpe_pkg::CFG_X_HIGH:  x_high_q  <= cfg_data;
				lpe_pkg::CFG_Y_LOW:   y_low_q   <= cfg_data;
				lpe_pkg::CFG_Y_HIGH:  y_high_q  <= cfg_data;
				lpe_pkg::CFG_X_ORDER: x_order_q <= cfg_data[2:0];
				lpe_pkg::CFG_Y_ORDER: y_order_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			idx_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && operation == lpe_pkg::OP_EVAL) begin
						if (rng_bad) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_AXES;
						end
					end
				end
				ST_AXES: begin
					i_q   <= '0;
					j_q   <= '0;
					idx_q <= '0;
					if (x_done && y_done) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					// slot index runs i + j*(xo+1), i.e. just counts up
					idx_q <= idx_q + 6'd1;
					if (i_q == xo) begin
						i_q <= '0;
						if (j_q == yo) begin
							state_q <= ST_DRAIN;
						end else begin
							j_q <= j_q + 3'd1;
						end
					end else begin
						i_q <= i_q + 3'd1;
					end
				end
				ST_DRAIN: begin
					if (!mac_sts.active) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			value_q   <= '0;
			rerr_q    <= 1'b1;
			sat_out_q <= 1'b0;
		end else begin
			value_q   <= acc;
			rerr_q    <= 1'b0;
			sat_out_q <= mac_sts.sat;
		end
	end

	lpe_axis #(.MAX_ORDER(MAX_ORDER)) u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ax_start),
		.coord  (x_coord),
		.lo     (x_low_q),
		.hi     (x_high_q),
		.order  (xo),
		.rd_idx (PW'(i_q)),
		.done   (x_done),
		.rd_val (px)
	);

	lpe_axis #(.MAX_ORDER(MAX_ORDER)) u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ax_start),
		.coord  (y_coord),
		.lo     (y_low_q),
		.hi     (y_high_q),
		.order  (yo),
		.rd_idx (PW'(j_q)),
		.done   (y_done),
		.rd_val (py)
	);

	lpe_mac #(.STORE_DEPTH(STORE_DEPTH)) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.rd_addr (idx_ext[AW-1:0]),
		.px      (px),
		.py      (py),
		.wr_en   (wr_en),
		.wr_addr (slot_ext[AW-1:0]),
		.wr_data (coef_word),
		.sts     (mac_sts),
		.acc     (acc)
	);

	assign done         = done_q;
	assign series_value = value_q;
	assign range_error  = rerr_q;
	assign saturated    = sat_out_q;

	`LPE_ASSERT_IMP(a_done_idle, done_q, state_q == ST_IDLE)
	`LPE_ASSERT_IMP(a_rerr_zero, done_q && rerr_q, value_q == '0 && !sat_out_q)
	`LPE_ASSERT_IMP(a_mac_axes, state_q == ST_MAC, x_done && y_done)
	`LPE_ASSERT_NXT(a_rerr_fast, accept && operation == lpe_pkg::OP_EVAL && rng_bad,
		done_q && rerr_q)

endmodule

### tb/tb_legendre_2d_poly_eval.sv
`timescale 1ns / 100ps

module tb_legendre_2d_poly_eval;

	localparam longint Q30_TOP   = 64'sd2147483647;
	localparam longint Q30_BOT   = -64'sd2147483648;
	localparam longint Q30_UNIT  = 64'sd1 << 30;
	localparam longint ACC_TOP   = 64'sh7fff_ffff_ffff_ffff;
	localparam longint ACC_BOT   = 64'sh8000_0000_0000_0000;
	localparam int     HANG_LIMIT = 5000;

	typedef struct {
		longint value;
		bit     range_err;
		bit     clipped;
	} series_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                operation;
	logic [5:0]          coef_slot;
	logic signed [31:0]  coef_word;
	logic signed [31:0]  x_coord;
	logic signed [31:0]  y_coord;
	logic                cfg_we;
	logic [2:0]          cfg_index;
	logic [31:0]         cfg_data;
	logic                done;
	logic signed [63:0]  series_value;
	logic                range_error;
	logic                saturated;

	// shadow of the block state
	longint  coef_mem [0:63];
	longint  rng_x_lo, rng_x_hi, rng_y_lo, rng_y_hi;
	int      deg_x, deg_y;

	series_t pending_series[$];
	bit      failed;
	bit      no_gaps;
	int      stall_cycles;

	legendre_2d_poly_eval i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.coef_slot   (coef_slot),
		.coef_word   (coef_word),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.series_value(series_value),
		.range_error (range_error),
		.saturated   (saturated)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint clip_q30(input longint v);
		if (v > Q30_TOP) return Q30_TOP;
		if (v < Q30_BOT) return Q30_BOT;
		return v;
	endfunction

	function automatic longint to_unit(input longint v, input longint lo, input longint hi);
		longint d, w, r;
		longint unsigned mag, q;
		d = v - lo;
		w = hi - lo;
		if (w < 0) begin
			w = -w;
			d = -d;
		end
		if (2 * d < -w) return Q30_BOT;
		if (2 * d >= 3 * w) return Q30_TOP;
		mag = longint'(d < 0 ? -d : d) << 31;
		q = (mag + longint'(w) / 2) / longint'(w);
		r = (d < 0) ? -longint'(q) : longint'(q);
		return clip_q30(r - Q30_UNIT);
	endfunction

	task automatic legendre_row(input longint r, input int deg, output longint p [0:7]);
		longint m, t, h, q;
		for (int k = 0; k < 8; k++) p[k] = 0;
		p[0] = Q30_UNIT;
		if (deg >= 1) p[1] = r;
		for (int n = 2; n <= deg; n++) begin
			m = (r * p[n-1] + (64'sd1 << 29)) >>> 30;
			t = longint'(2 * n - 1) * m - longint'(n - 1) * p[n-2];
			h = n / 2;
			q = (t >= 0) ? (t + h) / longint'(n) : -((-t + h) / longint'(n));
			p[n] = clip_q30(q);
		end
	endtask

	task automatic legendre_series(input longint xv, input longint yv, output series_t res);
		longint px [0:7];
		longint py [0:7];
		longint pr, term, acc;
		int     idx;
		res.value = 0;
		res.range_err = 0;
		res.clipped = 0;
		if (rng_x_hi == rng_x_lo || rng_y_hi == rng_y_lo) begin
			res.range_err = 1;
			return;
		end
		legendre_row(to_unit(xv, rng_x_lo, rng_x_hi), deg_x, px);
		legendre_row(to_unit(yv, rng_y_lo, rng_y_hi), deg_y, py);
		acc = 0;
		for (int j = 0; j <= deg_y; j++) begin
			for (int i = 0; i <= deg_x; i++) begin
				idx  = i + j * (deg_x + 1);
				pr   = clip_q30((px[i] * py[j] + (64'sd1 << 29)) >>> 30);
				term = ((idx < 64 ? coef_mem[idx] : 0) * pr + (64'sd1 << 13)) >>> 14;
				if (term > 0 && acc > ACC_TOP - term) begin
					acc = ACC_TOP;
					res.clipped = 1;
				end else if (term < 0 && acc < ACC_BOT - term) begin
					acc = ACC_BOT;
					res.clipped = 1;
				end else begin
					acc += term;
				end
			end
		end
		res.value = acc;
	endtask

	// block must be idle: all results in, then a margin for the last load
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_series.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_ranges(input longint xl, input longint xh, input longint yl,
			input longint yh, input int ox, input int oy);
		logic [31:0] vals [0:5];
		logic [2:0]  idxs [0:5];
		wait_idle();
		vals[0] = xl[31:0];
		vals[1] = xh[31:0];
		vals[2] = yl[31:0];
		vals[3] = yh[31:0];
		vals[4] = {$urandom} & 32'hffff_fff8 | ox;
		vals[5] = {$urandom} & 32'hffff_fff8 | oy;
		idxs[0] = lpe_pkg::CFG_X_LOW;
		idxs[1] = lpe_pkg::CFG_X_HIGH;
		idxs[2] = lpe_pkg::CFG_Y_LOW;
		idxs[3] = lpe_pkg::CFG_Y_HIGH;
		idxs[4] = lpe_pkg::CFG_X_ORDER;
		idxs[5] = lpe_pkg::CFG_Y_ORDER;
		for (int k = 0; k < 6; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idxs[k];
			cfg_data  <= vals[k];
			@(posedge clk);
		end
		cfg_we   <= 1'b0;
		rng_x_lo = longint'(signed'(vals[0]));
		rng_x_hi = longint'(signed'(vals[1]));
		rng_y_lo = longint'(signed'(vals[2]));
		rng_y_hi = longint'(signed'(vals[3]));
		deg_x    = vals[4] & 7;
		deg_y    = vals[5] & 7;
	endtask

	task automatic send_item(input logic op, input logic [5:0] slot, input logic [31:0] word,
			input logic [31:0] xv, input logic [31:0] yv);
		series_t res;
		if (!no_gaps && $urandom_range(3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(15, 1)) @(posedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		coef_slot <= slot;
		coef_word <= word;
		x_coord   <= xv;
		y_coord   <= yv;
		@(posedge clk);
		while (busy) @(posedge clk);
		// transfer done at this edge
		if (op == lpe_pkg::OP_LOAD) begin
			coef_mem[slot] = longint'(signed'(word));
		end else begin
			legendre_series(longint'(signed'(xv)), longint'(signed'(yv)), res);
			pending_series = {pending_series, res};
		end
	endtask

	function automatic logic [31:0] coord_near(input longint lo, input longint hi);
		longint a, b, span;
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		span = b - a;
		if ($urandom_range(9) < 2) return $urandom;
		if (span == 0) return a[31:0];
		return 32'(a + longint'({$urandom, $urandom} % (span + 1)));
	endfunction

	task automatic random_items(input int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) < 4)
				send_item(lpe_pkg::OP_LOAD, 6'($urandom), $urandom, $urandom, $urandom);
			else
				send_item(lpe_pkg::OP_EVAL, 6'($urandom), $urandom,
					coord_near(rng_x_lo, rng_x_hi), coord_near(rng_y_lo, rng_y_hi));
		end
	endtask

	task automatic test_fill_store();
		for (int s = 0; s < 64; s++)
			send_item(lpe_pkg::OP_LOAD, s[5:0],
				(s == 0) ? 32'h8000_0000 : (s == 1) ? 32'h7fff_ffff : $urandom, '0, '0);
	endtask

	task automatic test_directed();
		// reset ranges, order 0
		send_item(lpe_pkg::OP_EVAL, '0, '0, 32'h0000_8000, 32'h0000_8000);
		send_item(lpe_pkg::OP_EVAL, '0, '0, 32'h8000_0000, 32'h7fff_ffff);
		program_ranges(-65536, 65536, 65536, -65536, 7, 7);
		send_item(lpe_pkg::OP_EVAL, '0, '0, '0, '0);
		send_item(lpe_pkg::OP_EVAL, '0, '0, 32'hffff_0000, 32'h0001_0000);
		send_item(lpe_pkg::OP_EVAL, '0, '0, 32'h7fff_ffff, 32'h8000_0000);
		send_item(lpe_pkg::OP_EVAL, '0, '0, 32'h0003_0000, 32'hfffd_0000);
		// large coefficients with extrapolated points give a large sum, still short of clipping
		for (int s = 0; s < 64; s++)
			send_item(lpe_pkg::OP_LOAD, s[5:0], 32'h7fff_ffff, '0, '0);
		send_item(lpe_pkg::OP_EVAL, '0, '0, 32'h7fff_ffff, 32'h7fff_ffff);
		send_item(lpe_pkg::OP_EVAL, '0, '0, 32'h8000_0000, 32'h8000_0000);
		program_ranges(5000, 5000, 0, 65536, 3, 2);
		send_item(lpe_pkg::OP_EVAL, '0, '0, 32'd5000, 32'd100);
		program_ranges(-2147483648, 2147483647, 7, 7, 1, 0);
		send_item(lpe_pkg::OP_EVAL, '0, '0, '0, 32'd7);
		program_ranges(-2147483648, 2147483647, 2147483647, -2147483648, 7, 7);
		send_item(lpe_pkg::OP_EVAL, '0, '0, 32'h8000_0000, 32'h7fff_ffff);
		send_item(lpe_pkg::OP_EVAL, '0, '0, 32'h1234_5678, 32'hedcb_a988);
	endtask

	task automatic test_random_phases();
		longint lo, w;
		for (int ph = 0; ph < 12; ph++) begin
			lo = $signed($urandom) >>> $urandom_range(20, 0);
			w  = longint'($urandom_range(32'h7fff_ffff, 1)) >>> $urandom_range(20, 0);
			if (w == 0) w = 1;
			if (ph % 3 == 1) w = -w;
			if (ph == 4)
				program_ranges(lo, lo + w, lo, lo, 7, 7);
			else
				program_ranges(lo, lo + w, -lo, -lo + w / 3 + 1,
					(ph < 2) ? 7 * ph : $urandom_range(7), (ph < 2) ? 7 - 7 * ph : $urandom_range(7));
			random_items(130);
			if (ph == 6) begin
				wait_idle();
			end
		end
	endtask

	task automatic test_back_to_back();
		no_gaps = 1;
		program_ranges(-65536, 131072, 0, 262144, $urandom_range(7), $urandom_range(7));
		random_items(150);
		start <= 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		operation = 1'b0;
		coef_slot = '0;
		coef_word = '0;
		x_coord   = '0;
		y_coord   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		failed    = 0;
		no_gaps   = 0;
		rng_x_lo  = 0;
		rng_x_hi  = 65536;
		rng_y_lo  = 0;
		rng_y_hi  = 65536;
		deg_x     = 0;
		deg_y     = 0;
		for (int s = 0; s < 64; s++) coef_mem[s] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_store();
		test_directed();
		test_random_phases();
		test_back_to_back();
		while (pending_series.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (!failed)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		series_t want;
		if (arst_n && done) begin
			if (pending_series.size() == 0) begin
				$error("result with nothing expected: series_value %0d", series_value);
				failed = 1;
			end else begin
				want = pending_series.pop_front();
				if (series_value !== want.value) begin
					$error("series_value expected %0d actual %0d", want.value, series_value);
					failed = 1;
				end
				if (range_error !== want.range_err) begin
					$error("range_error expected %0d actual %0d", want.range_err, range_error);
					failed = 1;
				end
				if (saturated !== want.clipped) begin
					$error("saturated expected %0d actual %0d", want.clipped, saturated);
					failed = 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= HANG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial stall_cycles = 0;

endmodule
